// ----- src/mkde_pkg.sv -----
// Package for the multi-key debounce block: sizes, register indexes and the
// word types passed between the key lanes, the merge stage and the top level.
// No dependencies.
`default_nettype none

package mkde_pkg;

  // Keys handled side by side, and the timestamp width kept per key.
  localparam int KEY_COUNT = 4;
  localparam int TIME_BITS = 32;

  // Fixed field widths of the ports.
  localparam int NOW_W    = 32;
  localparam int MASK_W   = 4;
  localparam int DEB_W    = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [DEB_W-1:0]  DEBOUNCE_RESET = 16'd20;
  localparam logic [MASK_W-1:0] POLARITY_RESET = 4'd13;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE = 1'b0,
    REG_POLARITY = 1'b1
  } cfg_reg_t;

  // Per-key flags after one scan.
  typedef struct packed {
    logic pressed;
    logic press;
    logic release_ev;
  } lane_flags_t;

  // One result word.
  typedef struct packed {
    logic [MASK_W-1:0] pressed;
    logic [MASK_W-1:0] press;
    logic [MASK_W-1:0] release_ev;
  } out_word_t;

endpackage

`default_nettype wire

// ----- src/mkde_lane.sv -----
// One key lane: holds the debounce state of a single key and works out its
// flags for each accepted scan. Depends on mkde_pkg.
`default_nettype none

module mkde_lane
  import mkde_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 scan_fire,
  input  wire logic [TIME_BITS-1:0] now,
  input  wire logic                 raw,
  input  wire logic [DEB_W-1:0]     debounce,
  output lane_flags_t               flags_nxt
);

  logic                 last_raw_r, last_raw_nxt;
  logic                 stable_r, stable_nxt;
  logic [TIME_BITS-1:0] change_time_r, change_time_nxt;
  logic                 edge_done_r, edge_done_nxt;
  lane_flags_t          flags_r;
  logic [TIME_BITS-1:0] elapsed;
  logic                 held;

  assign elapsed = now - change_time_r;
  assign held    = elapsed >= {{(TIME_BITS-DEB_W){1'b0}}, debounce};

  always_comb begin
    last_raw_nxt    = last_raw_r;
    stable_nxt      = stable_r;
    change_time_nxt = change_time_r;
    edge_done_nxt   = edge_done_r;
    flags_nxt       = flags_r;
    if (raw != last_raw_r) begin
      // restart the window and drop both events
      last_raw_nxt         = raw;
      change_time_nxt      = now;
      edge_done_nxt        = 1'b0;
      flags_nxt.press      = 1'b0;
      flags_nxt.release_ev = 1'b0;
    end else if (held) begin
      stable_nxt        = raw;
      flags_nxt.pressed = raw;
      if (!edge_done_r && (raw != stable_r)) begin
        edge_done_nxt        = 1'b1;
        flags_nxt.press      = raw;
        flags_nxt.release_ev = ~raw;
      end else if (raw == stable_r) begin
        flags_nxt.press      = 1'b0;
        flags_nxt.release_ev = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_raw_r    <= 1'b0;
      stable_r      <= 1'b0;
      change_time_r <= '0;
      edge_done_r   <= 1'b0;
      flags_r       <= '0;
    end else if (scan_fire) begin
      last_raw_r    <= last_raw_nxt;
      stable_r      <= stable_nxt;
      change_time_r <= change_time_nxt;
      edge_done_r   <= edge_done_nxt;
      flags_r       <= flags_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- src/mkde_merge.sv -----
// Merge stage: gathers the lane flags into one result word and holds it in a
// two-word output queue that parts the scan side from the result side.
// Depends on mkde_pkg.
`default_nettype none

module mkde_merge
  import mkde_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        scan_fire,
  input  wire lane_flags_t lane_flags [KEY_COUNT],
  output logic             scan_ready,
  output logic             word_valid,
  input  wire logic        word_ready,
  output out_word_t        word
);

  out_word_t   merged;
  out_word_t   buf_r [2];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  count_r, count_nxt;
  logic        pop;

  always_comb begin
    merged = '0;
    for (int i = 0; i < KEY_COUNT; i++) begin
      if (i < MASK_W) begin
        merged.pressed[i]    = lane_flags[i].pressed;
        merged.press[i]      = lane_flags[i].press;
        merged.release_ev[i] = lane_flags[i].release_ev;
      end
    end
  end

  assign scan_ready = (count_r != 2'd2);
  assign word_valid = (count_r != 2'd0);
  assign word       = buf_r[rd_ptr_r];
  assign pop        = word_valid && word_ready;

  always_comb begin
    count_nxt = count_r;
    if (scan_fire && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (!scan_fire && pop) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_fire) begin
      buf_r[wr_ptr_r] <= merged;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (scan_fire) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("output queue count out of range");

  a_fill_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (scan_fire && !pop) |=> word_valid)
    else $error("accepted scan did not produce a word");

  a_press_pressed: assert property (@(posedge clk) disable iff (!rst_n)
    word_valid |-> ((word.press & ~word.pressed) == '0))
    else $error("press event on a key not pressed");

  a_release_clear: assert property (@(posedge clk) disable iff (!rst_n)
    word_valid |-> ((word.release_ev & word.pressed) == '0))
    else $error("release event on a key still pressed");

  a_no_both: assert property (@(posedge clk) disable iff (!rst_n)
    word_valid |-> ((word.press & word.release_ev) == '0))
    else $error("press and release event on the same key");

endmodule

`default_nettype wire

// ----- src/multi_key_debounce_edge_top.sv -----
// Top level of the multi-key debounce block: configuration registers, key
// lanes and merge stage. Depends on mkde_pkg, mkde_lane and mkde_merge.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_ready   in_now_ms, in_pin_levels
//   out_     output     out_valid / out_ready out_pressed_mask, out_press_event_mask,
//                                             out_release_event_mask
//   cfg_     input      cfg_wr_en             cfg_index, cfg_data
//
// One scan per cycle while in_ready is high; an accepted scan's word joins the output
// queue and shows on out_ after any waiting word. Every key lane does one subtract and compare per scan.
// A two-word output queue lets a scan be taken while a word waits; in_ready
// drops only when both queue slots are full.
// Synchronous reset clears all key state, the queue, and loads the register
// reset values.
`default_nettype none

module multi_key_debounce_edge_top
  import mkde_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [NOW_W-1:0]      in_now_ms,
  input  wire logic [MASK_W-1:0]     in_pin_levels,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [MASK_W-1:0]          out_pressed_mask,
  output logic [MASK_W-1:0]          out_press_event_mask,
  output logic [MASK_W-1:0]          out_release_event_mask,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic [DEB_W-1:0]     debounce_r;
  logic [MASK_W-1:0]    polarity_r;
  logic                 scan_fire;
  logic [KEY_COUNT-1:0] raw;
  lane_flags_t          lane_flags [KEY_COUNT];
  out_word_t            word;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= DEBOUNCE_RESET;
      polarity_r <= POLARITY_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DEBOUNCE: debounce_r <= cfg_data[DEB_W-1:0];
        REG_POLARITY: polarity_r <= cfg_data[MASK_W-1:0];
        default:      debounce_r <= debounce_r;
      endcase
    end
  end

  assign scan_fire = in_valid && in_ready;

  // map pin level to pressed; keys past the polarity mask read as not pressed
  always_comb begin
    raw = '0;
    for (int i = 0; i < KEY_COUNT; i++) begin
      if (i < MASK_W) begin
        raw[i] = (in_pin_levels[i] == polarity_r[i]);
      end
    end
  end

  for (genvar g = 0; g < KEY_COUNT; g++) begin : g_lane
    mkde_lane u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .scan_fire (scan_fire),
      .now       (in_now_ms[TIME_BITS-1:0]),
      .raw       (raw[g]),
      .debounce  (debounce_r),
      .flags_nxt (lane_flags[g])
    );
  end

  mkde_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .scan_fire  (scan_fire),
    .lane_flags (lane_flags),
    .scan_ready (in_ready),
    .word_valid (out_valid),
    .word_ready (out_ready),
    .word       (word)
  );

  assign out_pressed_mask       = word.pressed;
  assign out_press_event_mask   = word.press;
  assign out_release_event_mask = word.release_ev;

endmodule

`default_nettype wire
